[hw/rtl/gams_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gams_pkg
// Shared types and constants of the adjacency matrix store: request and
// status codes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package gams_pkg;

  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LABEL_REGS = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_BASE   = 3'd1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 3'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NONE     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    EMIT_NOTFOUND,
    EMIT_DONE,
    EMIT_SCAN
  } emit_e;

  // controller -> datapath
  typedef struct packed {
    logic  load;
    logic  find;
    logic  update;
    logic  load_row;
    logic  emit;
    emit_e emit_sel;
  } gams_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_rsvd;
    logic is_query;
    logic found1;
    logic found2;
    logic out_last;
  } gams_stat_t;

endpackage
`default_nettype wire

[hw/rtl/graph_adjacency_matrix_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// graph_adjacency_matrix_store
// Symmetric adjacency bit matrix of an undirected graph with labeled
// vertices: edge insert and delete, and neighbor listing in row order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       in_valid_i / in_ready_o    req_type, first/second_label
//  out       source     out_valid_o / out_ready_i  neighbor_label, status, last
//  cfg       sink       cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
//  One request at a time. Insert, delete and not-found answers pass through
//  lookup, execute and the result register before they are valid.
//  A query passes lookup, execute (row load) and a scan step before its first
//  result, and one more scan step after each result is taken: the scanner
//  hands out one neighbor per pass through the result register.
//  Reset clears the matrix and loads the default labels; no clearing pass.
//  A stalled result holds its register and the sequencer until taken.
// ----------------------------------------------------------------------------
module graph_adjacency_matrix_store
  import gams_pkg::*;
#(
  parameter int unsigned VERTICES = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LABEL_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [REQ_W-1:0]     req_type_i,
  input  wire logic [LABEL_W-1:0]   first_label_i,
  input  wire logic [LABEL_W-1:0]   second_label_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [LABEL_W-1:0]        neighbor_label_o,
  output logic [STAT_W-1:0]         status_o,
  output logic                      last_o
);

  gams_cmd_t  cmd;
  gams_stat_t stat;

  // sequencer
  gams_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  // matrix, lookup and result path
  gams_dp #(
    .VERTICES (VERTICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .first_label_i    (first_label_i),
    .second_label_i   (second_label_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .neighbor_label_o (neighbor_label_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

`ifndef SYNTHESIS
  // only one request in flight: never take input while a result is shown
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // a status other than done ends the request and carries no label
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (last_o && (neighbor_label_o == '0)))
    else $error("non-done result without last or with a label");

  // after the final transaction of a request the block is free again
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("block not free after final result");

  // a reserved request gives no result
  a_rsvd_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_RSVD)) |=> in_ready_o)
    else $error("reserved request was not dropped");
`endif

endmodule
`default_nettype wire

[hw/rtl/gams_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gams_ctrl
// Sequencer of the store: takes one request at a time, steps it through
// label lookup, execution and result delivery: a result per neighbor found, else one.
// ----------------------------------------------------------------------------
module gams_ctrl
  import gams_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       out_ready_i,
  input  wire gams_stat_t stat_i,
  output gams_cmd_t       cmd_o,
  output logic            in_ready_o,
  output logic            out_valid_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_sel = EMIT_DONE;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // drop a reserved request without a result
          if (!stat_i.in_rsvd) begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.is_query) begin
          if (stat_i.found1) begin
            cmd_o.load_row = 1'b1;
            state_d        = S_SCAN;
          end else begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_NOTFOUND;
            state_d        = S_OUT;
          end
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = S_OUT;
          if (stat_i.found1 && stat_i.found2) begin
            cmd_o.update   = 1'b1;
            cmd_o.emit_sel = EMIT_DONE;
          end else begin
            cmd_o.emit_sel = EMIT_NOTFOUND;
          end
        end
      end
      S_SCAN: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EMIT_SCAN;
        state_d        = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = stat_i.out_last ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/gams_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gams_dp
// Datapath of the store: configuration registers, request registers, label
// lookup, the symmetric adjacency matrix, the row scanner and the result
// register.
// ----------------------------------------------------------------------------
module gams_dp
  import gams_pkg::*;
#(
  parameter int unsigned VERTICES = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LABEL_W-1:0]   cfg_data_i,
  input  wire logic [REQ_W-1:0]     req_type_i,
  input  wire logic [LABEL_W-1:0]   first_label_i,
  input  wire logic [LABEL_W-1:0]   second_label_i,
  input  wire gams_cmd_t            cmd_i,
  output gams_stat_t                stat_o,
  output logic [LABEL_W-1:0]        neighbor_label_o,
  output logic [STAT_W-1:0]         status_o,
  output logic                      last_o
);

  localparam int unsigned RowW      = $clog2(VERTICES);
  localparam int unsigned LabelRegs = (VERTICES < LABEL_REGS) ? VERTICES : LABEL_REGS;

  logic [CNT_W-1:0]    vcount_q;
  logic [LABEL_W-1:0]  label_q [LabelRegs];
  logic [LABEL_W-1:0]  lbl_w   [VERTICES];
  logic [CNT_W-1:0]    active_w;
  logic [VERTICES-1:0] act_mask_w;

  req_e               req_q;
  logic [LABEL_W-1:0] lbl1_q, lbl2_q;
  logic [RowW-1:0]    r1_q, r2_q, idx1_w, idx2_w;
  logic               f1_q, f2_q, hit1_w, hit2_w;

  logic [VERTICES-1:0] adj_q [VERTICES];
  logic [VERTICES-1:0] scan_q, scan_rest_w;
  logic [RowW-1:0]     low_idx_w;

  logic [LABEL_W-1:0] nb_q;
  status_e            st_q;
  logic               last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VERTEX_COUNT_RST;
      for (int i = 0; i < LabelRegs; i++) begin
        label_q[i] <= LABEL_W'(i);
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_VERTEX_COUNT) begin
        vcount_q <= cfg_data_i[CNT_W-1:0];
      end
      for (int i = 0; i < LabelRegs; i++) begin
        if (cfg_index_i == CFG_LABEL_BASE + CFG_IDX_W'(i)) begin
          label_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // row labels: rows past the register file keep their row number
  for (genvar j = 0; j < VERTICES; j++) begin : g_lbl
    if (j < LabelRegs) begin : g_reg
      assign lbl_w[j] = label_q[j];
    end else begin : g_fix
      assign lbl_w[j] = LABEL_W'(j);
    end
    assign act_mask_w[j] = (CNT_W'(j) < active_w);
  end

  // clamp the active count to the matrix size
  assign active_w = (vcount_q > CNT_W'(VERTICES)) ? CNT_W'(VERTICES) : vcount_q;

  // capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_e'(req_type_i);
      lbl1_q <= first_label_i;
      lbl2_q <= second_label_i;
    end
  end

  // lowest active row matching each label
  always_comb begin
    hit1_w = 1'b0;
    hit2_w = 1'b0;
    idx1_w = '0;
    idx2_w = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (act_mask_w[i] && (lbl_w[i] == lbl1_q)) begin
        hit1_w = 1'b1;
        idx1_w = RowW'(i);
      end
      if (act_mask_w[i] && (lbl_w[i] == lbl2_q)) begin
        hit2_w = 1'b1;
        idx2_w = RowW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      r1_q <= idx1_w;
      r2_q <= idx2_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else if (cmd_i.find) begin
      f1_q <= hit1_w;
      f2_q <= hit2_w;
    end
  end

  // adjacency matrix: set or clear both mirrored bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VERTICES; i++) begin
        adj_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < VERTICES; i++) begin
        for (int j = 0; j < VERTICES; j++) begin
          if (((RowW'(i) == r1_q) && (RowW'(j) == r2_q)) ||
              ((RowW'(i) == r2_q) && (RowW'(j) == r1_q))) begin
            adj_q[i][j] <= (req_q == REQ_INSERT);
          end
        end
      end
    end
  end

  // row scanner: lowest pending neighbor and what remains after it
  always_comb begin
    low_idx_w = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (scan_q[i]) begin
        low_idx_w = RowW'(i);
      end
    end
  end

  assign scan_rest_w = scan_q & (scan_q - VERTICES'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.load_row) begin
      scan_q <= adj_q[r1_q] & act_mask_w;
    end else if (cmd_i.emit && (cmd_i.emit_sel == EMIT_SCAN)) begin
      scan_q <= scan_rest_w;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        EMIT_NOTFOUND: begin
          nb_q <= '0;
          st_q <= ST_NOTFOUND;
        end
        EMIT_SCAN: begin
          if (scan_q == '0) begin
            nb_q <= '0;
            st_q <= ST_NONE;
          end else begin
            nb_q <= lbl_w[low_idx_w];
            st_q <= ST_DONE;
          end
        end
        default: begin
          nb_q <= '0;
          st_q <= ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.emit) begin
      if (cmd_i.emit_sel == EMIT_SCAN) begin
        last_q <= (scan_q == '0) || (scan_rest_w == '0);
      end else begin
        last_q <= 1'b1;
      end
    end
  end

  // status toward the controller
  assign stat_o.in_rsvd  = (req_type_i == REQ_RSVD);
  assign stat_o.is_query = (req_q == REQ_QUERY);
  assign stat_o.found1   = f1_q;
  assign stat_o.found2   = f2_q;
  assign stat_o.out_last = last_q;

  assign neighbor_label_o = nb_q;
  assign status_o         = st_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire

[tb/graph_adjacency_matrix_store_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_adjacency_matrix_store_tb
// Self-checking bench for the labeled adjacency matrix store. A shadow copy
// of the labels, the vertex count and the bit matrix predicts the answers of
// every accepted request. A checker compares each result transaction with the
// oldest predicted answer. Directed tests cover the reset state, edge ops and
// register corner cases. Random traffic then runs under several register
// settings with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module graph_adjacency_matrix_store_tb;
  import gams_pkg::*;

  localparam int VERTICES      = 5;
  localparam int ITEM_TARGET   = 470;
  localparam int PHASE_ITEMS   = 60;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [LABEL_W-1:0] nb;
    status_e            st;
    logic               last;
  } adj_answer_t;

  // DUT inputs, known from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [LABEL_W-1:0]   cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic [REQ_W-1:0]     req_type_i     = '0;
  logic [LABEL_W-1:0]   first_label_i  = '0;
  logic [LABEL_W-1:0]   second_label_i = '0;
  logic                 out_ready_i    = 1'b0;
  // DUT outputs
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [LABEL_W-1:0]   neighbor_label_o;
  logic [STAT_W-1:0]    status_o;
  logic                 last_o;

  // shadow of the block
  logic [CNT_W-1:0]    vcount_cfg;
  logic [LABEL_W-1:0]  label_cfg [VERTICES];
  logic [VERTICES-1:0] adj_rows  [VERTICES];

  adj_answer_t pending_answers[$];
  adj_answer_t oldest_answer;

  int  mismatch_count = 0;
  int  requests_sent  = 0;
  int  answers_seen   = 0;
  int  regs_written   = 0;
  bit  steady         = 1'b0;
  int  hold_reqs      = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;

  graph_adjacency_matrix_store #(
    .VERTICES(VERTICES)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .first_label_i,
    .second_label_i,
    .out_valid_o,
    .out_ready_i,
    .neighbor_label_o,
    .status_o,
    .last_o
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Shadow model
  // ------------------------------------------------------------------------
  function automatic int live_rows();
    return (vcount_cfg > VERTICES) ? VERTICES : int'(vcount_cfg);
  endfunction

  // lowest active row carrying the label, -1 when none
  function automatic int lookup_row(logic [LABEL_W-1:0] lbl);
    int n;
    n = live_rows();
    for (int i = 0; i < n; i++) begin
      if (label_cfg[i] == lbl) return i;
    end
    return -1;
  endfunction

  function automatic void expect_answer(logic [LABEL_W-1:0] nb, status_e st, logic last);
    adj_answer_t a;
    a.nb   = nb;
    a.st   = st;
    a.last = last;
    pending_answers.push_back(a);
  endfunction

  // update the shadow matrix and queue the answers of one request
  function automatic void compute_answers(logic [REQ_W-1:0] req, logic [LABEL_W-1:0] a,
                                          logic [LABEL_W-1:0] b);
    int ra;
    int rb;
    int n;
    int hits;
    int given;
    ra = lookup_row(a);
    n  = live_rows();
    case (req)
      REQ_RSVD: begin
      end
      REQ_QUERY: begin
        if (ra < 0) begin
          expect_answer('0, ST_NOTFOUND, 1'b1);
        end else begin
          hits = 0;
          for (int j = 0; j < n; j++) hits += adj_rows[ra][j];
          if (hits == 0) begin
            expect_answer('0, ST_NONE, 1'b1);
          end else begin
            given = 0;
            for (int j = 0; j < n; j++) begin
              if (adj_rows[ra][j]) begin
                given++;
                expect_answer(label_cfg[j], ST_DONE, given == hits);
              end
            end
          end
        end
      end
      default: begin
        rb = lookup_row(b);
        if (ra < 0 || rb < 0) begin
          expect_answer('0, ST_NOTFOUND, 1'b1);
        end else begin
          adj_rows[ra][rb] = (req == REQ_INSERT);
          adj_rows[rb][ra] = (req == REQ_INSERT);
          expect_answer('0, ST_DONE, 1'b1);
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random ready, hold-off on request, field checks
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t ERROR unexpected result: label %0d status %0d last %0d",
                 $time, neighbor_label_o, status_o, last_o);
      end else begin
        oldest_answer = pending_answers.pop_front();
        answers_seen++;
        if (neighbor_label_o !== oldest_answer.nb) begin
          mismatch_count++;
          $display("%0t ERROR neighbor_label expected %0d actual %0d",
                   $time, oldest_answer.nb, neighbor_label_o);
        end
        if (status_o !== oldest_answer.st) begin
          mismatch_count++;
          $display("%0t ERROR status expected %0d actual %0d",
                   $time, oldest_answer.st, status_o);
        end
        if (last_o !== oldest_answer.last) begin
          mismatch_count++;
          $display("%0t ERROR last expected %0d actual %0d",
                   $time, oldest_answer.last, last_o);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------
  // offer one request, hold it until accepted, then maybe idle a while;
  // the gap reaches past the busy cycles of the block so that the input
  // also sits idle while ready
  task automatic send_request(logic [REQ_W-1:0] req, logic [LABEL_W-1:0] a,
                              logic [LABEL_W-1:0] b);
    int gap;
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    first_label_i  <= a;
    second_label_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    compute_answers(req, a, b);
    if (req != REQ_RSVD) requests_sent++;
    if (!steady && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid, wait for every answer, then let the block settle
  task automatic wait_idle();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_answers.size() != 0) begin
      mismatch_count++;
      $display("%0t ERROR %0d expected results never arrived", $time,
               pending_answers.size());
      pending_answers.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write; the caller lowers the enable after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LABEL_W-1:0] data);
    int row;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    row = int'(idx) - int'(CFG_LABEL_BASE);
    if (idx == CFG_VERTEX_COUNT) vcount_cfg = data[CNT_W-1:0];
    else if (row >= 0 && row < LABEL_REGS && row < VERTICES) label_cfg[row] = data;
    regs_written++;
  endtask

  // mostly a label of an active row, sometimes anything
  function automatic logic [LABEL_W-1:0] pick_label();
    int n;
    n = live_rows();
    if (n > 0 && $urandom_range(99) < 85) return label_cfg[$urandom_range(n - 1)];
    return LABEL_W'($urandom_range(255));
  endfunction

  task automatic send_random_request();
    int pick;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(99);
    if (pick < 38)      req = REQ_INSERT;
    else if (pick < 58) req = REQ_DELETE;
    else if (pick < 94) req = REQ_QUERY;
    else                req = REQ_RSVD;
    send_request(req, pick_label(), pick_label());
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // empty matrix with default labels, unknown labels, reserved request
  task automatic test_reset_state();
    send_request(REQ_QUERY, 8'd0, 8'd255);
    send_request(REQ_QUERY, 8'd4, 8'd0);
    send_request(REQ_QUERY, 8'd5, 8'd0);
    send_request(REQ_INSERT, 8'd7, 8'd1);
    send_request(REQ_DELETE, 8'd1, 8'd200);
    send_request(REQ_RSVD, 8'd0, 8'd1);
  endtask

  // insert, delete, self loop, duplicate insert, deleting an absent edge
  task automatic test_edge_ops();
    send_request(REQ_INSERT, 8'd0, 8'd1);
    send_request(REQ_INSERT, 8'd4, 8'd0);
    send_request(REQ_INSERT, 8'd2, 8'd2);
    send_request(REQ_INSERT, 8'd0, 8'd1);
    send_request(REQ_QUERY, 8'd0, 8'd0);
    send_request(REQ_QUERY, 8'd2, 8'd0);
    send_request(REQ_QUERY, 8'd1, 8'd0);
    send_request(REQ_DELETE, 8'd1, 8'd0);
    send_request(REQ_QUERY, 8'd0, 8'd0);
    send_request(REQ_DELETE, 8'd3, 8'd3);
    send_request(REQ_QUERY, 8'd3, 8'd0);
  endtask

  // extreme and duplicate labels, shrunk count with stale bits, zero and
  // oversized counts, a write to an unused index
  task automatic test_register_settings();
    wait_idle();
    write_reg(CFG_LABEL_BASE,        8'd255);
    write_reg(CFG_LABEL_BASE + 3'd1, 8'h80);
    write_reg(CFG_LABEL_BASE + 3'd2, 8'd255);
    write_reg(CFG_LABEL_BASE + 3'd3, 8'h55);
    write_reg(CFG_LABEL_BASE + 3'd4, 8'hAA);
    write_reg(3'd7, 8'hFF);
    cfg_we_i <= 1'b0;
    send_request(REQ_INSERT, 8'd255, 8'h80);
    send_request(REQ_QUERY, 8'd255, 8'd0);
    wait_idle();
    write_reg(CFG_VERTEX_COUNT, 8'd2);
    cfg_we_i <= 1'b0;
    send_request(REQ_QUERY, 8'd255, 8'd0);
    send_request(REQ_QUERY, 8'hAA, 8'd0);
    wait_idle();
    write_reg(CFG_VERTEX_COUNT, 8'd7);
    cfg_we_i <= 1'b0;
    send_request(REQ_QUERY, 8'd255, 8'd0);
    wait_idle();
    write_reg(CFG_VERTEX_COUNT, 8'd0);
    cfg_we_i <= 1'b0;
    send_request(REQ_INSERT, 8'd255, 8'd255);
    send_request(REQ_QUERY, 8'd0, 8'd0);
    wait_idle();
    write_reg(CFG_VERTEX_COUNT, 8'hFD);
    cfg_we_i <= 1'b0;
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_backpressure();
    wait_idle();
    steady = 1'b0;
    hold_reqs++;
    repeat (12) send_random_request();
    wait_idle();
  endtask

  // random traffic in phases, each under a fresh register setting
  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int count;
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      wait_idle();
      case (phase % 8)
        0: count = 5;
        1: count = 1;
        2: count = 3;
        3: count = 7;
        4: count = 0;
        5: count = 4;
        6: count = 2;
        default: count = 6;
      endcase
      write_reg(CFG_VERTEX_COUNT, {LABEL_W'($urandom_range(31)) << CNT_W} | LABEL_W'(count));
      if (phase % 2 == 1) begin
        for (int r = 0; r < LABEL_REGS; r++) begin
          case ($urandom_range(5))
            0: write_reg(CFG_LABEL_BASE + CFG_IDX_W'(r), 8'd0);
            1: write_reg(CFG_LABEL_BASE + CFG_IDX_W'(r), 8'd255);
            2: write_reg(CFG_LABEL_BASE + CFG_IDX_W'(r), LABEL_W'($urandom_range(3)));
            default: write_reg(CFG_LABEL_BASE + CFG_IDX_W'(r), LABEL_W'($urandom_range(255)));
          endcase
        end
        write_reg(CFG_IDX_W'($urandom_range(6, 7)), LABEL_W'($urandom_range(255)));
      end
      cfg_we_i <= 1'b0;
      steady = (phase == 2);
      if (phase == 5) hold_reqs++;
      // a zero count makes every label unknown, so keep that phase short
      phase_end = requests_sent + ((count == 0) ? PHASE_ITEMS / 4 : PHASE_ITEMS);
      while (requests_sent < phase_end && requests_sent < ITEM_TARGET) send_random_request();
      phase++;
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    vcount_cfg = VERTEX_COUNT_RST;
    for (int i = 0; i < VERTICES; i++) begin
      label_cfg[i] = LABEL_W'(i);
      adj_rows[i]  = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_edge_ops();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("Covered %0d requests and %0d checked results across %0d register writes,",
             requests_sent, answers_seen, regs_written);
    $display("including zero, clipped and shrunk vertex counts and receiver hold-offs.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
